// ===== sv/nvrgb_pkg.sv =====
// Shared types and constants for the NV21 to RGBA converter.
package nvrgb_pkg;

    localparam int ADDR_W    = 19;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int TERM_W    = 20;
    localparam int SUM_W     = 22;

    localparam logic [1:0] CFG_HALF_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HALF_HEIGHT = 2'd1;

    localparam logic [9:0] HW_RESET = 10'd160;
    localparam logic [8:0] HH_RESET = 9'd120;
    localparam logic [9:0] HW_MAX   = 10'd512;
    localparam logic [8:0] HH_MAX   = 9'd256;

    localparam logic [7:0] LUMA_OFS   = 8'd16;
    localparam logic [7:0] CHROMA_OFS = 8'd128;
    localparam logic [7:0] ALPHA      = 8'hff;

    localparam logic [10:0] K_Y = 11'd1192;
    localparam logic signed [TERM_W-1:0] K_RV = 20'sd1634;
    localparam logic signed [TERM_W-1:0] K_GV = 20'sd833;
    localparam logic signed [TERM_W-1:0] K_GU = 20'sd400;
    localparam logic signed [TERM_W-1:0] K_BU = 20'sd2066;
    localparam logic signed [SUM_W-1:0] CLAMP_MAX = 22'sd262143;

    typedef enum logic [1:0] {
        ST_LUMA,
        ST_CHROMA_V,
        ST_CHROMA_U,
        ST_FETCH
    } state_t;

    typedef struct packed {
        logic                     last;
        logic signed [TERM_W-1:0] rv;
        logic signed [TERM_W-1:0] gv;
        logic signed [TERM_W-1:0] bu;
    } pix_meta_t;

    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
        pix_meta_t         meta;
    } mem_req_t;

    typedef struct packed {
        logic              valid;
        logic [7:0]        luma;
        logic [ADDR_W-1:0] idx;
        pix_meta_t         meta;
    } rd_beat_t;

endpackage

// ===== sv/nvrgb_parse.sv =====
// Frame byte parser, config registers and luma read sequencer.
module nvrgb_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [9:0]           cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 issue_ok,
    output nvrgb_pkg::mem_req_t  req
);
    import nvrgb_pkg::*;

    state_t            state_reg, state_next;
    logic [9:0]        hw_reg, hw_next;
    logic [8:0]        hh_reg, hh_next;
    logic [9:0]        xcnt_reg, xcnt_next;
    logic [8:0]        ycnt_reg, ycnt_next;
    logic [ADDR_W-1:0] luma_addr_reg, luma_addr_next;
    logic [ADDR_W-1:0] tl_reg, tl_next;
    logic [7:0]        held_v_reg, held_v_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0] job_tl_reg, job_tl_next;
    pix_meta_t         job_reg, job_next;

    logic                     accept;
    logic                     cfg_hit;
    logic [10:0]              w;
    logic [9:0]               w_last;
    logic [8:0]               h_last;
    logic                     blk_row_end;
    logic                     blk_last;
    logic signed [TERM_W-1:0] v_s;
    logic signed [TERM_W-1:0] u_s;
    pix_meta_t                fresh;

    function automatic logic [9:0] eff_hw(input logic [9:0] x);
        if (x == 10'd0)
            return 10'd1;
        else if (x > HW_MAX)
            return HW_MAX;
        else
            return x;
    endfunction

    function automatic logic [8:0] eff_hh(input logic [8:0] x);
        if (x == 9'd0)
            return 9'd1;
        else if (x > HH_MAX)
            return HH_MAX;
        else
            return x;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg != ST_FETCH);
    assign accept    = s_tvalid && s_tready;
    assign cfg_hit   = cfg_valid && (cfg_index == CFG_HALF_WIDTH || cfg_index == CFG_HALF_HEIGHT);

    assign w           = {hw_reg, 1'b0};
    assign w_last      = 10'(w - 11'd1);
    assign h_last      = 9'({hh_reg, 1'b0} - 10'd1);
    assign blk_row_end = (xcnt_reg == 10'(hw_reg - 10'd1));
    assign blk_last    = blk_row_end && (ycnt_reg == 9'(hh_reg - 9'd1));

    assign v_s = $signed({12'd0, held_v_reg}) - $signed({12'd0, CHROMA_OFS});
    assign u_s = $signed({12'd0, s_tdata}) - $signed({12'd0, CHROMA_OFS});

    always_comb
    begin
        fresh.last = 1'b0;
        fresh.rv   = v_s * K_RV;
        fresh.gv   = -(v_s * K_GV) - (u_s * K_GU);
        fresh.bu   = u_s * K_BU;
    end

    always_comb
    begin
        state_next     = state_reg;
        hw_next        = hw_reg;
        hh_next        = hh_reg;
        xcnt_next      = xcnt_reg;
        ycnt_next      = ycnt_reg;
        luma_addr_next = luma_addr_reg;
        tl_next        = tl_reg;
        held_v_next    = held_v_reg;
        cnt_next       = cnt_reg;
        job_tl_next    = job_tl_reg;
        job_next       = job_reg;
        req            = '0;

        case (state_reg)
            ST_LUMA:
            begin
                if (accept)
                begin
                    req.wr         = 1'b1;
                    req.addr       = luma_addr_reg;
                    req.wdata      = s_tdata;
                    luma_addr_next = luma_addr_reg + 1'b1;
                    if (xcnt_reg == w_last)
                    begin
                        xcnt_next = '0;
                        if (ycnt_reg == h_last)
                        begin
                            ycnt_next      = '0;
                            luma_addr_next = '0;
                            state_next     = ST_CHROMA_V;
                        end
                        else
                        begin
                            ycnt_next = ycnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        xcnt_next = xcnt_reg + 1'b1;
                    end
                end
            end
            ST_CHROMA_V:
            begin
                if (accept)
                begin
                    held_v_next = s_tdata;
                    state_next  = ST_CHROMA_U;
                end
            end
            ST_CHROMA_U:
            begin
                if (accept)
                begin
                    job_next      = fresh;
                    job_next.last = blk_last;
                    job_tl_next   = tl_reg;
                    state_next    = ST_FETCH;
                    cnt_next      = 2'd0;
                    if (issue_ok)
                    begin
                        // top-left read goes out with the U beat
                        req.rd    = 1'b1;
                        req.addr  = tl_reg;
                        req.meta  = fresh;
                        cnt_next  = 2'd1;
                    end
                    if (blk_last)
                    begin
                        xcnt_next = '0;
                        ycnt_next = '0;
                        tl_next   = '0;
                    end
                    else if (blk_row_end)
                    begin
                        xcnt_next = '0;
                        ycnt_next = ycnt_reg + 1'b1;
                        tl_next   = tl_reg + ADDR_W'(w) + ADDR_W'(2);
                    end
                    else
                    begin
                        xcnt_next = xcnt_reg + 1'b1;
                        tl_next   = tl_reg + ADDR_W'(2);
                    end
                end
            end
            ST_FETCH:
            begin
                if (issue_ok)
                begin
                    req.rd        = 1'b1;
                    req.addr      = job_tl_reg + (cnt_reg[1] ? ADDR_W'(w) : '0)
                                    + ADDR_W'(cnt_reg[0]);
                    req.meta      = job_reg;
                    req.meta.last = job_reg.last && (cnt_reg == 2'd3);
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_reg == 2'd3)
                        state_next = job_reg.last ? ST_LUMA : ST_CHROMA_V;
                end
            end
            default:
            begin
                state_next = ST_LUMA;
            end
        endcase

        if (cfg_hit)
        begin
            if (cfg_index == CFG_HALF_WIDTH)
                hw_next = eff_hw(cfg_data);
            else
                hh_next = eff_hh(cfg_data[8:0]);
            state_next     = ST_LUMA;
            xcnt_next      = '0;
            ycnt_next      = '0;
            luma_addr_next = '0;
            tl_next        = '0;
            held_v_next    = '0;
            cnt_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LUMA;
            hw_reg        <= HW_RESET;
            hh_reg        <= HH_RESET;
            xcnt_reg      <= '0;
            ycnt_reg      <= '0;
            luma_addr_reg <= '0;
            tl_reg        <= '0;
            held_v_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hw_reg        <= hw_next;
            hh_reg        <= hh_next;
            xcnt_reg      <= xcnt_next;
            ycnt_reg      <= ycnt_next;
            luma_addr_reg <= luma_addr_next;
            tl_reg        <= tl_next;
            held_v_reg    <= held_v_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_tl_reg <= job_tl_next;
        job_reg    <= job_next;
    end

endmodule

// ===== sv/nvrgb_store.sv =====
// Single-port luma store with registered read data and its metadata stage.
module nvrgb_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nvrgb_pkg::mem_req_t  req,
    input  logic                 take,
    output logic                 issue_ok,
    output nvrgb_pkg::rd_beat_t  rd
);
    import nvrgb_pkg::*;

    logic [7:0]        luma_mem [MEM_DEPTH];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] idx_reg;
    pix_meta_t         meta_reg;
    logic              valid_reg, valid_next;

    assign issue_ok = !valid_reg || take;

    always_comb
    begin
        if (req.rd)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req.wr)
            luma_mem[req.addr] <= req.wdata;
        if (req.rd)
        begin
            rdata_reg <= luma_mem[req.addr];
            idx_reg   <= req.addr;
            meta_reg  <= req.meta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_comb
    begin
        rd.valid = valid_reg;
        rd.luma  = rdata_reg;
        rd.idx   = idx_reg;
        rd.meta  = meta_reg;
    end

endmodule

// ===== sv/nvrgb_pixel.sv =====
// Color math and output register for one pixel per beat.
module nvrgb_pixel (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nvrgb_pkg::rd_beat_t  rd,
    output logic                 take,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,
    output logic                 m_tlast
);
    import nvrgb_pkg::*;

    logic                    out_valid_reg, out_valid_next;
    logic [55:0]             out_data_reg;
    logic                    out_last_reg;
    logic [7:0]              y;
    logic [18:0]             ys;
    logic signed [SUM_W-1:0] ys_s;
    logic [7:0]              r, g, b;
    logic [31:0]             word;

    function automatic logic [7:0] clamp_chan(input logic signed [SUM_W-1:0] s);
        if (s < 0)
            return 8'd0;
        else if (s > CLAMP_MAX)
            return 8'hff;
        else
            return s[17:10];
    endfunction

    assign take = !out_valid_reg || m_tready;

    assign y    = (rd.luma < LUMA_OFS) ? 8'd0 : rd.luma - LUMA_OFS;
    assign ys   = 19'(y * K_Y);
    assign ys_s = $signed({3'd0, ys});
    assign r    = clamp_chan(ys_s + SUM_W'(rd.meta.rv));
    assign g    = clamp_chan(ys_s + SUM_W'(rd.meta.gv));
    assign b    = clamp_chan(ys_s + SUM_W'(rd.meta.bu));
    assign word = {ALPHA, b, g, r};

    assign out_valid_next = take ? rd.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && rd.valid)
        begin
            out_data_reg <= {5'd0, word, rd.idx};
            out_last_reg <= rd.meta.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/nv21_to_rgba_converter.sv =====
// Top level of the NV21 to RGBA8888 converter.
// Luma and V beats are taken as they arrive; a U beat starts the four luma reads of its
// 2x2 block on the single-port store, and s_tready stays low until all four are issued.
// The first pixel of a block passes the store's read register and the output register
// before m_tvalid; the other three follow one per cycle while m_tready is high.
// Reset clears the frame position, held V byte and pipeline; half_width returns to 160
// and half_height to 120. The luma store is not cleared.
module nv21_to_rgba_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [18:0] pixel_index, [50:19] pixel_word, [55:51] zero
    output logic        m_tlast    // last_of_frame
);
    import nvrgb_pkg::*;

    mem_req_t req;
    rd_beat_t rd;
    logic     issue_ok;
    logic     take;

    nvrgb_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .issue_ok  (issue_ok),
        .req       (req)
    );

    nvrgb_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .take     (take),
        .issue_ok (issue_ok),
        .rd       (rd)
    );

    nvrgb_pixel u_pixel (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sv/nvrgb_checker.sv =====
// Port-level checks for the converter, bound to the top level.
module nvrgb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[50:43] == 8'hff)
        else $error("alpha byte not 0xff");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[55:51] == 5'd0)
        else $error("tdata pad bits not zero");

    a_last_odd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[0])
        else $error("last pixel is not a bottom-right pixel");

endmodule

bind nv21_to_rgba_converter nvrgb_checker u_nvrgb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/nv21_to_rgba_converter_tb.sv =====
// Self-checking testbench for the NV21 to RGBA8888 converter.
`timescale 1ns / 1ps

module nv21_to_rgba_converter_tb;
    import nvrgb_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int STUCK_LIMIT   = 5000;
    localparam int STALL_PHASE   = 14;
    localparam int EXT_CAP       = 16;

    typedef struct packed {
        logic [18:0] index;
        logic [31:0] word;
        logic        last;
    } rgba_pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] frame_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // [18:0] pixel_index, [50:19] pixel_word, [55:51] zero
    logic        m_tlast;        // last_of_frame

    logic [7:0]  frame_bytes[$];
    rgba_pixel_t due_pixels[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req = 0;
    int          hold_seen;
    int          hold_left;
    int          stuck;
    int          bad_beats = 0;

    // predictor state
    logic [7:0]  luma_mem [MEM_DEPTH];
    logic [9:0]  hw_reg;
    logic [8:0]  hh_reg;
    logic [7:0]  held_v;
    int unsigned frame_pos;

    nv21_to_rgba_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] clamp_channel(input int x);
        int c;
        c = x;
        if (c < 0)
            c = 0;
        else if (c > int'(CLAMP_MAX))
            c = int'(CLAMP_MAX);
        return c[17:10];
    endfunction

    task automatic absorb_frame_byte(input logic [7:0] b);
        int unsigned hw, hh, w, npix, total, c, k, row, col, idx;
        int          y, ys, v, u;
        rgba_pixel_t px;
        hw = (hw_reg == 0) ? 1 : (hw_reg > HW_MAX) ? HW_MAX : hw_reg;
        hh = (hh_reg == 0) ? 1 : (hh_reg > HH_MAX) ? HH_MAX : hh_reg;
        w = hw * 2;
        npix = w * hh * 2;
        total = npix + npix / 2;
        if (frame_pos >= total)
            frame_pos = 0;
        if (frame_pos < npix)
            luma_mem[frame_pos % MEM_DEPTH] = b;
        else
        begin
            c = frame_pos - npix;
            if (!c[0])
                held_v = b;
            else
            begin
                k = c >> 1;
                row = (k / hw) * 2;
                col = (k % hw) * 2;
                v = int'(held_v) - int'(CHROMA_OFS);
                u = int'(b) - int'(CHROMA_OFS);
                // 2x2 block: top-left, top-right, bottom-left, bottom-right
                for (int dr = 0; dr < 2; dr++)
                begin
                    for (int dc = 0; dc < 2; dc++)
                    begin
                        idx = (row + dr) * w + col + dc;
                        y = int'(luma_mem[idx % MEM_DEPTH]) - int'(LUMA_OFS);
                        if (y < 0)
                            y = 0;
                        ys = int'(K_Y) * y;
                        px.index = idx[18:0];
                        px.word = {ALPHA,
                                   clamp_channel(ys + int'(K_BU) * u),
                                   clamp_channel(ys - int'(K_GV) * v - int'(K_GU) * u),
                                   clamp_channel(ys + int'(K_RV) * v)};
                        px.last = (idx == npix - 1);
                        due_pixels.push_back(px);
                    end
                end
            end
        end
        frame_pos++;
        if (frame_pos >= total)
            frame_pos = 0;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (frame_bytes.size() > 0 && int'($urandom_range(99)) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= frame_bytes.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output ready, with the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : beat_monitor
        rgba_pixel_t want;
        if (!rst_n)
        begin
            hw_reg = HW_RESET;
            hh_reg = HH_RESET;
            held_v = '0;
            frame_pos = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HALF_WIDTH:  hw_reg = cfg_data;
                    CFG_HALF_HEIGHT: hh_reg = cfg_data[8:0];
                    default: ;
                endcase
                if (cfg_index == CFG_HALF_WIDTH || cfg_index == CFG_HALF_HEIGHT)
                begin
                    frame_pos = 0;
                    held_v = '0;
                end
            end
            if (s_tvalid && s_tready)
                absorb_frame_byte(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (due_pixels.size() == 0)
                begin
                    $error("unexpected pixel beat, pixel_index %0d", m_tdata[18:0]);
                    bad_beats++;
                end
                else
                begin
                    want = due_pixels.pop_front();
                    if (m_tdata[18:0] !== want.index)
                    begin
                        $error("pixel_index: expected %0d, got %0d", want.index, m_tdata[18:0]);
                        bad_beats++;
                    end
                    if (m_tdata[50:19] !== want.word)
                    begin
                        $error("pixel_word: expected %h, got %h", want.word, m_tdata[50:19]);
                        bad_beats++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_frame: expected %b, got %b", want.last, m_tlast);
                        bad_beats++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck == STUCK_LIMIT)
        begin
            $display("** nv21_to_rgba_converter: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] index, input logic [9:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random_bytes(input int n);
        repeat (n)
            frame_bytes.push_back(8'($urandom));
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (frame_bytes.size() != 0 || s_tvalid || due_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [9:0]  ext_hw [5];
        logic [9:0]  ext_hh [5];
        logic [9:0]  hw_sel, hh_sel;
        int unsigned ehw, ehh, flen, budget, sent;
        ext_hw = '{10'd0, 10'd512, 10'd1, 10'd1023, 10'd1};
        ext_hh = '{10'd0, 10'd1, 10'd256, 10'd0, 10'h3ff};
        send_idle_pct = 29;
        recv_idle_pct = 79;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // a few luma bytes at the reset geometry, then a restart
        @(negedge clk);
        frame_bytes = {frame_bytes, 8'd200, 8'd7};
        wait_idle();
        write_reg(CFG_HALF_WIDTH, 10'd1);
        write_reg(CFG_HALF_HEIGHT, 10'd1);

        // 2x2 frames: chroma at both ends, luma around the black floor
        @(negedge clk);
        frame_bytes = {frame_bytes,
                       8'd0,   8'd255, 8'd16,  8'd17,  8'd0,   8'd255,
                       8'd255, 8'd15,  8'd1,   8'd254, 8'd255, 8'd0,
                       8'd128, 8'd235, 8'd240, 8'd16,  8'd128, 8'd128,
                       8'd90,  8'd60,  8'd30};
        wait_idle();

        // width change mid-frame restarts; 4x2, stop between V and U
        write_reg(CFG_HALF_WIDTH, 10'd2);
        @(negedge clk);
        queue_random_bytes(11);
        wait_idle();
        // unused index must not restart the frame
        write_reg(CFG_SPARE, 10'($urandom));
        @(negedge clk);
        queue_random_bytes(13);
        wait_idle();

        for (int phase = 0; phase < 18; phase++)
        begin
            case (phase / 6)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase % 3 == 0 && phase < 15)
            begin
                hw_sel = ext_hw[phase / 3];
                hh_sel = ext_hh[phase / 3];
                budget = 1;
            end
            else
            begin
                hw_sel = 10'($urandom_range(3, 1));
                hh_sel = 10'($urandom_range(2, 1));
                budget = (phase == STALL_PHASE) ? 60 : 12;
            end
            if ($urandom_range(1))
            begin
                write_reg(CFG_HALF_WIDTH, hw_sel);
                write_reg(CFG_HALF_HEIGHT, hh_sel);
            end
            else
            begin
                write_reg(CFG_HALF_HEIGHT, hh_sel);
                write_reg(CFG_HALF_WIDTH, hw_sel);
            end
            ehw = (hw_sel == 0) ? 1 : (hw_sel > HW_MAX) ? HW_MAX : hw_sel;
            ehh = (hh_sel[8:0] == 0) ? 1 : (hh_sel[8:0] > HH_MAX) ? HH_MAX : hh_sel[8:0];
            flen = 6 * ehw * ehh;
            // large geometries get only the head of a frame
            if (budget == 1 && flen > EXT_CAP)
                flen = EXT_CAP;
            @(negedge clk);
            if (phase == STALL_PHASE)
                hold_req++;
            sent = 0;
            do
            begin
                queue_random_bytes(flen);
                sent += flen;
            end
            while (sent < budget);
            if (budget > 1 && $urandom_range(1))
                queue_random_bytes($urandom_range(flen - 1, 1));
            wait_idle();
        end

        if (bad_beats == 0)
            $display("** nv21_to_rgba_converter: PASSED **");
        else
            $display("** nv21_to_rgba_converter: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/nvrgb_pkg.sv
sv/nvrgb_parse.sv
sv/nvrgb_store.sv
sv/nvrgb_pixel.sv
sv/nv21_to_rgba_converter.sv
sv/nvrgb_checker.sv
test/nv21_to_rgba_converter_tb.sv
